// ===== src/ftcp_pkg.sv =====
`default_nettype none
package ftcp_pkg;

	// request kinds passed from the front to the back
	localparam logic [1:0] EV_CLEAR = 2'd0;
	localparam logic [1:0] EV_CHAR  = 2'd1;
	localparam logic [1:0] EV_CLOSE = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} ev_t;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_NODIGIT = 2'd2;
	localparam logic [1:0] ST_OVF     = 2'd3;

	// commands
	localparam logic [2:0] CMD_STOP  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_DZ    = 3'd2;
	localparam logic [2:0] CMD_TO    = 3'd3;
	localparam logic [2:0] CMD_KP    = 3'd4;
	localparam logic [2:0] CMD_KI    = 3'd5;
	localparam logic [2:0] CMD_KD    = 3'd6;
	localparam logic [2:0] CMD_THS   = 3'd7;

	// keyword match phases
	localparam logic [3:0] PH_NUM  = 4'd14;
	localparam logic [3:0] PH_FAIL = 4'd15;

	// number parse phases
	localparam logic [2:0] NP_WS   = 3'd0;
	localparam logic [2:0] NP_SIGN = 3'd1;
	localparam logic [2:0] NP_INT  = 3'd2;
	localparam logic [2:0] NP_FRAC = 3'd3;
	localparam logic [2:0] NP_DROP = 3'd4;
	localparam logic [2:0] NP_DONE = 3'd5;

	localparam logic [31:0] ACC_MAX  = 32'hFFFF_FFFF;
	localparam logic [3:0]  FRAC_MAX = 4'd9;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// keyword text, indexed by command code, zero padded to five characters
	localparam logic [7:0] KW_TEXT [0:7][0:4] = '{
		'{"S", "T", "O", "P", 8'h00},
		'{"S", "T", "A", "R", "T"},
		'{"D", "Z", "=", 8'h00, 8'h00},
		'{"T", "O", "=", 8'h00, 8'h00},
		'{"K", "P", "=", 8'h00, 8'h00},
		'{"K", "I", "=", 8'h00, 8'h00},
		'{"K", "D", "=", 8'h00, 8'h00},
		'{"T", "H", "S", "=", 8'h00}
	};
	localparam logic [2:0] KW_LEN [0:7] = '{3'd4, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4};

endpackage
`default_nettype wire

// ===== src/framed_tuning_command_parser.sv =====
`default_nettype none
// A closing '#' request goes through a queue slot, then the result register, to result_valid.
// Throughput: one byte per clock; the front only stalls when the two-entry queue is full,
// which happens only while a finished result is held by result_stall.
// A held result does not stop byte intake until the queue behind it fills.
// Reset (arst_n low, asynchronous): no frame open, queue empty, no result pending.
module framed_tuning_command_parser import ftcp_pkg::*; #(
	parameter int MAX_BODY = 63
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// byte channel
	input  wire logic         byte_valid,
	output logic              byte_stall,
	input  wire logic [7:0]   rx_byte,
	// result channel
	output logic              result_valid,
	input  wire logic         result_stall,
	output logic [1:0]        status,
	output logic [2:0]        command,
	output logic signed [32:0] mantissa,
	output logic [3:0]        frac_digits
);

	// front: framing, body length, end of text; it turns bytes into requests
	ev_t  push_ev;
	logic push;
	// queue between front and back
	ev_t  head_ev;
	logic q_empty;
	logic q_full;
	logic pop;

	assign byte_stall = q_full;

	ftcp_front #(
		.MAX_BODY (MAX_BODY)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.rx_byte    (rx_byte),
		.queue_full (q_full),
		.push_ev    (push_ev),
		.push       (push)
	);

	ftcp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.pop     (pop),
		.head_ev (head_ev),
		.empty   (q_empty),
		.full    (q_full)
	);

	// back: keyword match, decimal conversion, result register
	ftcp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_ev      (head_ev),
		.empty        (q_empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.command      (command),
		.mantissa     (mantissa),
		.frac_digits  (frac_digits)
	);

endmodule
`default_nettype wire

// ===== src/ftcp_front.sv =====
`default_nettype none
module ftcp_front import ftcp_pkg::*; #(
	parameter int MAX_BODY = 63
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	input  wire logic [7:0] rx_byte,
	input  wire logic       queue_full,
	output ev_t             push_ev,
	output logic            push
);

	localparam int CNT_W = $clog2(MAX_BODY + 1);

	logic             in_frame_q, in_frame_d;
	logic [CNT_W-1:0] body_cnt_q, body_cnt_d;
	logic             text_end_q, text_end_d;
	logic             accept;

	assign accept = byte_valid && !queue_full;

	always_comb begin
		in_frame_d   = in_frame_q;
		body_cnt_d   = body_cnt_q;
		text_end_d   = text_end_q;
		push         = 1'b0;
		push_ev.kind = EV_CHAR;
		push_ev.data = rx_byte;
		if (accept) begin
			if (rx_byte == CH_DOLLAR) begin
				in_frame_d   = 1'b1;
				body_cnt_d   = '0;
				text_end_d   = 1'b0;
				push         = 1'b1;
				push_ev.kind = EV_CLEAR;
			end else if (in_frame_q) begin
				if (rx_byte == CH_HASH) begin
					in_frame_d   = 1'b0;
					push         = 1'b1;
					push_ev.kind = EV_CLOSE;
				end else if (body_cnt_q >= CNT_W'(MAX_BODY)) begin
					// overlong body: drop the frame silently
					in_frame_d = 1'b0;
				end else begin
					body_cnt_d = body_cnt_q + CNT_W'(1);
					if (!text_end_q) begin
						if (rx_byte == CH_NUL) begin
							text_end_d = 1'b1;
						end else begin
							push = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			body_cnt_q <= '0;
			text_end_q <= 1'b0;
		end else begin
			in_frame_q <= in_frame_d;
			body_cnt_q <= body_cnt_d;
			text_end_q <= text_end_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/ftcp_queue.sv =====
`default_nettype none
module ftcp_queue import ftcp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  ev_t       push_ev,
	input  wire logic pop,
	output ev_t       head_ev,
	output logic      empty,
	output logic      full
);

	ev_t        slot_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign head_ev = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

// ===== src/ftcp_back.sv =====
`default_nettype none
module ftcp_back import ftcp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  ev_t               head_ev,
	input  wire logic         empty,
	output logic              pop,
	output logic              result_valid,
	input  wire logic         result_stall,
	output logic [1:0]        status,
	output logic [2:0]        command,
	output logic signed [32:0] mantissa,
	output logic [3:0]        frac_digits
);

	logic [3:0]  mp_q, mp_d;
	logic [2:0]  g_q, g_d;
	logic [2:0]  np_q, np_d;
	logic        neg_q, neg_d;
	logic [31:0] acc_q, acc_d;
	logic [3:0]  frac_q, frac_d;
	logic        seen_q, seen_d;
	logic        ovf_q, ovf_d;

	logic        res_valid_q;
	logic [1:0]  res_status_q;
	logic [2:0]  res_cmd_q;
	logic [32:0] res_mant_q;
	logic [3:0]  res_frac_q;

	logic [7:0]  c;
	logic        is_digit;
	logic        is_ws;
	logic        is_float;
	logic [35:0] acc_x10;
	logic        fits;
	logic        kw_found;
	logic [2:0]  kw_g;
	logic        pref;
	logic [3:0]  p_next;
	logic        close_now;

	logic [1:0]  st_c;
	logic [2:0]  cmd_c;
	logic [32:0] mant_c;
	logic [3:0]  frac_c;

	assign c        = head_ev.data;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign is_float = (g_q != CMD_TO);
	// acc*10 + digit as two shifted adds
	assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {32'd0, c[3:0] & {4{is_digit}}};
	assign fits     = (acc_x10[35:32] == 4'd0);

	assign pop       = !empty && ((head_ev.kind != EV_CLOSE) || !res_valid_q || !result_stall);
	assign close_now = pop && (head_ev.kind == EV_CLOSE);

	// keyword step: first keyword sharing the matched prefix that takes this char
	always_comb begin
		kw_found = 1'b0;
		kw_g     = g_q;
		for (int k = 0; k < 8; k++) begin
			pref = 1'b1;
			for (int i = 0; i < 4; i++) begin
				if ((4'(i) < mp_q) && (KW_TEXT[k][i] != KW_TEXT[g_q][i])) begin
					pref = 1'b0;
				end
			end
			if (!kw_found && ({1'b0, KW_LEN[k]} > mp_q) && pref
				&& (KW_TEXT[k][mp_q[2:0]] == c)) begin
				kw_found = 1'b1;
				kw_g     = 3'(k);
			end
		end
	end

	assign p_next = mp_q + 4'd1;

	always_comb begin
		mp_d   = mp_q;
		g_d    = g_q;
		np_d   = np_q;
		neg_d  = neg_q;
		acc_d  = acc_q;
		frac_d = frac_q;
		seen_d = seen_q;
		ovf_d  = ovf_q;
		if (pop) begin
			case (head_ev.kind)
				EV_CLEAR: begin
					mp_d   = 4'd0;
					g_d    = CMD_STOP;
					np_d   = NP_WS;
					neg_d  = 1'b0;
					acc_d  = '0;
					frac_d = '0;
					seen_d = 1'b0;
					ovf_d  = 1'b0;
				end
				EV_CHAR: begin
					if (mp_q == PH_NUM) begin
						if (np_q >= NP_DONE) begin
							np_d = np_q;
						end else if ((np_q == NP_WS) && is_ws) begin
							np_d = np_q;
						end else if ((np_q == NP_WS) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
							neg_d = (c == CH_MINUS);
							np_d  = NP_SIGN;
						end else if (np_q <= NP_INT) begin
							if (is_digit) begin
								seen_d = 1'b1;
								np_d   = NP_INT;
								if (!ovf_q) begin
									if (fits) begin
										acc_d = acc_x10[31:0];
									end else begin
										acc_d = ACC_MAX;
										ovf_d = 1'b1;
									end
								end
							end else if ((c == CH_DOT) && is_float) begin
								np_d = ovf_q ? NP_DROP : NP_FRAC;
							end else begin
								np_d = NP_DONE;
							end
						end else if (!is_digit) begin
							np_d = NP_DONE;
						end else begin
							seen_d = 1'b1;
							if (np_q == NP_FRAC) begin
								if ((frac_q < FRAC_MAX) && fits) begin
									acc_d  = acc_x10[31:0];
									frac_d = frac_q + 4'd1;
								end else begin
									np_d = NP_DROP;
								end
							end
						end
					end else if (mp_q == PH_FAIL) begin
						mp_d = PH_FAIL;
					end else if (mp_q >= {1'b0, KW_LEN[g_q]}) begin
						mp_d = PH_FAIL;
					end else if (!kw_found) begin
						mp_d = PH_FAIL;
					end else begin
						g_d = kw_g;
						if ((p_next == {1'b0, KW_LEN[kw_g]}) && (kw_g >= CMD_DZ)) begin
							mp_d = PH_NUM;
						end else begin
							mp_d = p_next;
						end
					end
				end
				default: begin
					mp_d = mp_q;
				end
			endcase
		end
	end

	// result of a closing request
	always_comb begin
		st_c   = ST_UNKNOWN;
		cmd_c  = CMD_STOP;
		mant_c = '0;
		frac_c = '0;
		if (mp_q == PH_NUM) begin
			cmd_c = g_q;
			if (!seen_q) begin
				st_c = ST_NODIGIT;
			end else begin
				st_c   = ovf_q ? ST_OVF : ST_OK;
				mant_c = neg_q ? (33'd0 - {1'b0, acc_q}) : {1'b0, acc_q};
				frac_c = frac_q;
			end
		end else if ((mp_q < PH_NUM) && (mp_q == {1'b0, KW_LEN[g_q]})) begin
			st_c  = ST_OK;
			cmd_c = g_q;
		end
	end

	always_ff @(posedge clk) begin
		if (close_now) begin
			res_status_q <= st_c;
			res_cmd_q    <= cmd_c;
			res_mant_q   <= mant_c;
			res_frac_q   <= frac_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_q        <= 4'd0;
			g_q         <= CMD_STOP;
			np_q        <= NP_WS;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			frac_q      <= '0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			mp_q   <= mp_d;
			g_q    <= g_d;
			np_q   <= np_d;
			neg_q  <= neg_d;
			acc_q  <= acc_d;
			frac_q <= frac_d;
			seen_q <= seen_d;
			ovf_q  <= ovf_d;
			if (close_now) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status       = res_status_q;
	assign command      = res_cmd_q;
	assign mantissa     = res_mant_q;
	assign frac_digits  = res_frac_q;

	a_num_has_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(mp_q == PH_NUM) |-> (g_q >= CMD_DZ))
		else $error("number phase without a prefixed command");
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> ((acc_q == ACC_MAX) && (frac_q == 4'd0)))
		else $error("overflow flag without saturated magnitude");
	a_close_loads: assert property (@(posedge clk) disable iff (!arst_n)
		close_now |=> res_valid_q)
		else $error("closing request did not produce a result");

endmodule
`default_nettype wire

// ===== tb/sv/framed_tuning_command_parser_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels, runs its own parser on every accepted byte and
// compares each accepted result with the oldest one it has worked out.
module framed_tuning_command_parser_checker import ftcp_pkg::*; #(
	parameter int MAX_BODY = 63
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_valid,
	input  wire logic         byte_stall,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         result_valid,
	input  wire logic         result_stall,
	input  wire logic [1:0]   status,
	input  wire logic [2:0]   command,
	input  wire logic [32:0]  mantissa,
	input  wire logic [3:0]   frac_digits,
	output int                mismatches,
	output int                reports_due
);

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  command;
		logic [32:0] mantissa;
		logic [3:0]  frac;
	} frame_report_t;

	frame_report_t frame_reports [$];
	int errors;

	// parser state
	bit          open;
	int          body_len;
	logic [3:0]  kw_pos;
	logic [2:0]  kw_pick;
	bit          nul_seen;
	logic [2:0]  num_step;
	bit          minus;
	logic [31:0] magnitude;
	logic [3:0]  frac_kept;
	bit          any_digit;
	bit          saturated;

	function automatic string kw_word(input logic [2:0] k);
		case (k)
			CMD_STOP:  return "STOP";
			CMD_START: return "START";
			CMD_DZ:    return "DZ=";
			CMD_TO:    return "TO=";
			CMD_KP:    return "KP=";
			CMD_KI:    return "KI=";
			CMD_KD:    return "KD=";
			CMD_THS:   return "THS=";
			default:   return "";
		endcase
	endfunction

	task automatic clear_frame();
		body_len = 0;
		kw_pos = 4'd0;
		kw_pick = CMD_STOP;
		nul_seen = 1'b0;
		num_step = NP_WS;
		minus = 1'b0;
		magnitude = 32'd0;
		frac_kept = 4'd0;
		any_digit = 1'b0;
		saturated = 1'b0;
	endtask

	task automatic report(input string what, input logic [32:0] got, input logic [32:0] want);
		$display("%0t %s: got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic parse_byte(input logic [7:0] c);
		string cur, cand;
		logic [2:0] g;
		logic [35:0] grown;
		logic [3:0] d;
		int p;
		bit found, same, digit, space;
		frame_report_t rep;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		d = 4'(c - CH_ZERO);
		grown = 36'(magnitude) * 36'd10 + 36'(d);
		if (c == CH_DOLLAR) begin
			open = 1'b1;
			clear_frame();
		end else if (open && c == CH_HASH) begin
			open = 1'b0;
			rep.status = ST_UNKNOWN;
			rep.command = CMD_STOP;
			rep.mantissa = 33'd0;
			rep.frac = 4'd0;
			cur = kw_word(kw_pick);
			if (kw_pos == PH_NUM) begin
				rep.command = kw_pick;
				if (!any_digit) begin
					rep.status = ST_NODIGIT;
				end else begin
					rep.status = saturated ? ST_OVF : ST_OK;
					rep.mantissa = minus ? -{1'b0, magnitude} : {1'b0, magnitude};
					rep.frac = frac_kept;
				end
			end else if (kw_pos < PH_NUM && int'(kw_pos) == cur.len()) begin
				rep.status = ST_OK;
				rep.command = kw_pick;
			end
			frame_reports.push_back(rep);
		end else if (open && body_len >= MAX_BODY) begin
			// body full: the frame dies without a result
			open = 1'b0;
		end else if (open) begin
			body_len++;
			if (!nul_seen && kw_pos != PH_FAIL) begin
				if (c == CH_NUL) begin
					nul_seen = 1'b1;
				end else if (kw_pos == PH_NUM) begin
					if (num_step < NP_DONE && !(num_step == NP_WS && space)) begin
						if (num_step == NP_WS && (c == CH_PLUS || c == CH_MINUS)) begin
							minus = (c == CH_MINUS);
							num_step = NP_SIGN;
						end else if (num_step <= NP_INT) begin
							if (digit) begin
								any_digit = 1'b1;
								if (!saturated) begin
									if (grown > 36'(ACC_MAX)) begin
										magnitude = ACC_MAX;
										saturated = 1'b1;
									end else begin
										magnitude = grown[31:0];
									end
								end
								num_step = NP_INT;
							end else if (c == CH_DOT && kw_pick != CMD_TO) begin
								num_step = saturated ? NP_DROP : NP_FRAC;
							end else begin
								num_step = NP_DONE;
							end
						end else if (!digit) begin
							num_step = NP_DONE;
						end else begin
							any_digit = 1'b1;
							if (num_step == NP_FRAC) begin
								if (frac_kept < FRAC_MAX && grown <= 36'(ACC_MAX)) begin
									magnitude = grown[31:0];
									frac_kept++;
								end else begin
									num_step = NP_DROP;
								end
							end
						end
					end
				end else begin
					// keyword: first candidate that agrees with the text so far
					g = kw_pick;
					p = int'(kw_pos);
					cur = kw_word(g);
					if (p >= cur.len()) begin
						kw_pos = PH_FAIL;
					end else begin
						found = 1'b0;
						for (int k = 0; k < 8; k++) begin
							cand = kw_word(3'(k));
							same = 1'b1;
							for (int i = 0; i < p; i++)
								if (cand[i] != cur[i]) same = 1'b0;
							if (!found && same && cand.len() > p && cand[p] == c) begin
								g = 3'(k);
								found = 1'b1;
							end
						end
						if (!found) begin
							kw_pos = PH_FAIL;
						end else begin
							kw_pick = g;
							cur = kw_word(g);
							p++;
							kw_pos = (p == cur.len() && cur[p - 1] == "=") ? PH_NUM : 4'(p);
						end
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open = 1'b0;
			clear_frame();
			frame_reports.delete();
			errors = 0;
			mismatches <= 0;
			reports_due <= 0;
		end else begin
			if (byte_valid && !byte_stall)
				parse_byte(rx_byte);
			if (result_valid && !result_stall) begin
				if (frame_reports.size() == 0) begin
					report("result with none due, status", 33'(status), 33'd0);
				end else begin
					frame_report_t want;
					want = frame_reports.pop_front();
					if (status != want.status)
						report("status", 33'(status), 33'(want.status));
					if (command != want.command)
						report("command", 33'(command), 33'(want.command));
					if (mantissa != want.mantissa)
						report("mantissa", mantissa, want.mantissa);
					if (frac_digits != want.frac)
						report("frac_digits", 33'(frac_digits), 33'(want.frac));
				end
			end
			mismatches <= errors;
			reports_due <= frame_reports.size();
		end
	end

endmodule

// ===== tb/sv/framed_tuning_command_parser_test.sv =====
`timescale 1ns / 100ps
// Top of the parser bench: builds byte streams, drives the byte channel,
// throttles the result channel and gives the verdict. All prediction and
// comparison lives in the checker instance.
module framed_tuning_command_parser_test import ftcp_pkg::*;;

	localparam int MAX_BODY     = 63;
	localparam int TOTAL_BYTES  = 1050;
	localparam int IDLE_LIMIT   = 1000;  // cycles in which neither channel moves a request
	localparam int TAIL_CYCLES  = 8;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  rx_byte;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  status;
	logic [2:0]  command;
	logic signed [32:0] mantissa;
	logic [3:0]  frac_digits;
	int          mismatches;
	int          reports_due;

	// stimulus bookkeeping
	logic [7:0]  frame_bytes [$];
	int          sent;
	bit          burst;       // when set, the current frame goes out back to back
	int          stall_hold;

	framed_tuning_command_parser #(
		.MAX_BODY(MAX_BODY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.command(command),
		.mantissa(mantissa),
		.frac_digits(frac_digits)
	);

	framed_tuning_command_parser_checker #(
		.MAX_BODY(MAX_BODY)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.rx_byte(rx_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.command(command),
		.mantissa(mantissa),
		.frac_digits(frac_digits),
		.mismatches(mismatches),
		.reports_due(reports_due)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side back-pressure: random runs of stall and no stall.
	// Stall runs are mostly short with an occasional long one; the open runs
	// are sometimes long so that stretches with no stall at all also occur.
	always @(posedge clk) begin
		if (stall_hold == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
					: $urandom_range(1, 4);
			end else begin
				result_stall <= 1'b0;
				stall_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100)
					: $urandom_range(1, 6);
			end
		end else begin
			stall_hold--;
		end
	end

	// Watchdog: the run dies if neither channel moves a request for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("framed_tuning_command_parser: mismatch");
		$finish;
	end

	task automatic put_byte(input logic [7:0] b);
		frame_bytes.push_back(b);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// first n characters of a keyword
	task automatic put_kw(input logic [2:0] k, input int n);
		for (int i = 0; i < n; i++)
			put_byte(KW_TEXT[k][i]);
	endtask

	task automatic put_digits(input int n);
		repeat (n) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// One well-formed command frame with random content, appended to the
	// byte list. Numbers get optional white space, sign, integer digits
	// (now and then right at the saturation edge), fraction and junk after.
	task automatic make_command();
		int k, r;
		k = $urandom_range(0, 7);
		put_byte(CH_DOLLAR);
		put_kw(3'(k), int'(KW_LEN[k]));
		if (k <= CMD_START) begin
			// trailing text makes STOP / START unknown
			if ($urandom_range(0, 9) == 0)
				put_byte(8'($urandom_range(33, 126)));
		end else begin
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3))
					put_byte(($urandom_range(0, 1) == 0) ? CH_SPACE
						: CH_TAB + 8'($urandom_range(0, 4)));
			r = $urandom_range(0, 3);
			if (r == 0)
				put_byte(CH_PLUS);
			else if (r == 1)
				put_byte(CH_MINUS);
			r = $urandom_range(0, 99);
			if (r < 4)
				put_text("4294967295");
			else if (r < 8)
				put_text("4294967296");
			else if (r < 13)
				put_digits(0);
			else if (r < 75)
				put_digits($urandom_range(1, 4));
			else if (r < 93)
				put_digits($urandom_range(5, 9));
			else
				put_digits($urandom_range(10, 12));
			if ($urandom_range(0, 2) == 0) begin
				put_byte(CH_DOT);
				put_digits(($urandom_range(0, 4) == 0) ? $urandom_range(5, 11)
					: $urandom_range(0, 4));
			end
			if ($urandom_range(0, 7) == 0)
				put_byte(8'($urandom_range(33, 126)));
		end
		put_byte(CH_HASH);
	endtask

	// Drive every queued byte as one request each. Gaps before a byte are
	// mostly zero, often short and rarely long; burst frames have none.
	task automatic send_frame();
		int gap, roll;
		foreach (frame_bytes[i]) begin
			gap = 0;
			if (!burst) begin
				roll = $urandom_range(0, 99);
				if (roll >= 97)
					gap = $urandom_range(25, 60);
				else if (roll >= 88)
					gap = $urandom_range(4, 12);
				else if (roll >= 55)
					gap = $urandom_range(1, 3);
			end
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			byte_valid <= 1'b1;
			rx_byte <= frame_bytes[i];
			@(posedge clk);
			while (byte_stall) @(posedge clk);
			sent++;
		end
		frame_bytes.delete();
	endtask

	// Hold the sender until every predicted result has been taken. The first
	// edge lets the checker's count catch up with the last request.
	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int pick, k, n, spot;
		bit paused;
		logic [7:0] b;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		rx_byte = 8'h00;
		sent = 0;
		burst = 1'b0;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames: every command, sign and white space handling,
		// saturation, fraction truncation, TO without fraction, missing
		// digits, unknown keywords, restart, bytes outside a frame and the
		// zero byte that ends the text.
		put_text("ab$STOP#");
		put_text("$START#");
		put_text("$DZ=1.5#");
		put_text("$TO=-42#");
		put_text("$TO=3.5#");
		put_text("$KP=+0.25#");
		put_text("$KI= \t\n7#");
		put_text("$KD=-0#");
		put_text("$THS=4294967295#");
		put_text("$THS=-4294967296.5#");
		put_text("$KI=1.1234567891#");
		put_text("$KD=4294967.2959#");
		put_text("$KP=#");
		put_text("$KP=-.#");
		put_text("$KP=.5#");
		put_text("$STOPX#");
		put_text("$STO#");
		put_text("$#");
		put_text("$ST$START#");
		put_text("$XYZ=1#");
		put_text("#9$DZ=7x9#");
		put_text("$KP=5");
		put_byte(CH_NUL);
		put_text("9#");
		put_text("$KP");
		put_byte(CH_NUL);
		put_text("=5#");
		put_byte(CH_DOLLAR);
		put_byte(8'hFF);
		put_byte(CH_HASH);
		put_text("$DZ=00000000000004294967295#");
		send_frame();
		drain();

		// Random part: mostly well-formed frames, the rest damaged ones,
		// restarts, noise, full-length bodies and bytes outside any frame.
		while (sent < TOTAL_BYTES) begin
			burst = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, 7);
			if (pick < 55) begin
				make_command();
			end else if (pick < 70) begin
				// one byte replaced, often by the zero byte
				make_command();
				spot = $urandom_range(1, frame_bytes.size() - 2);
				frame_bytes[spot] = ($urandom_range(0, 2) == 0) ? CH_NUL
					: 8'($urandom_range(0, 255));
			end else if (pick < 76) begin
				put_byte(CH_DOLLAR);
				put_kw(3'(k), $urandom_range(0, KW_LEN[k]));
				put_byte(CH_HASH);
			end else if (pick < 82) begin
				// frame cut short by a fresh '$'
				put_byte(CH_DOLLAR);
				put_kw(3'(k), $urandom_range(0, KW_LEN[k]));
				put_digits($urandom_range(0, 3));
				make_command();
			end else if (pick < 88) begin
				put_byte(CH_DOLLAR);
				repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
				put_byte(CH_HASH);
			end else if (pick < 94) begin
				// body right around the length limit
				put_byte(CH_DOLLAR);
				put_kw(3'(k), int'(KW_LEN[k]));
				n = $urandom_range(61, 65) - KW_LEN[k];
				repeat (n) begin
					b = ($urandom_range(0, 1) == 0) ? CH_ZERO + 8'($urandom_range(0, 9))
						: 8'($urandom_range(0, 255));
					if (b == CH_DOLLAR || b == CH_HASH)
						b = CH_SPACE;
					put_byte(b);
				end
				put_byte(CH_HASH);
			end else begin
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
			end
			send_frame();
			if (!paused && sent >= TOTAL_BYTES / 2) begin
				paused = 1'b1;
				drain();
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && reports_due == 0)
			$display("framed_tuning_command_parser: match");
		else
			$display("framed_tuning_command_parser: mismatch");
		$finish;
	end

endmodule
